### rtl/crat_pkg.sv
package crat_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam logic [31:0] TIMEOUT_RESET = 32'd80000;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_REG   = 2'd0;
    localparam t_mode MODE_HB    = 2'd1;
    localparam t_mode MODE_SWEEP = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_NEW     = 3'd0;
    localparam t_status ST_KNOWN   = 3'd1;
    localparam t_status ST_HB_OK   = 3'd2;
    localparam t_status ST_UNKNOWN = 3'd3;
    localparam t_status ST_FULL    = 3'd4;
    localparam t_status ST_SWEPT   = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seen;
        logic [31:0] addr;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

    typedef struct packed {
        logic hit;
        logic keep;
    } t_cmp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

### rtl/crat_table.sv
module crat_table (
    input  logic                          i_clk,
    input  crat_pkg::t_wr_req             i_wr,
    input  logic [crat_pkg::IDX_W-1:0]    i_rd_addr,
    output crat_pkg::t_entry              o_rd_data
);

    crat_pkg::t_entry r_mem [crat_pkg::CAPACITY];
    crat_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/crat_unit.sv
module crat_unit (
    input  logic [31:0]    i_x,
    input  logic [31:0]    i_y,
    input  logic [31:0]    i_limit,
    output crat_pkg::t_cmp o_res
);

    // one subtractor: zero difference for lookup, modular age for sweep
    logic [31:0] diff;

    assign diff       = i_x - i_y;
    assign o_res.hit  = (diff == 32'd0);
    assign o_res.keep = (diff <= i_limit);

endmodule

### rtl/crat_ctrl.sv
module crat_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  crat_pkg::t_mode               i_mode,
    input  logic [31:0]                   i_addr,
    input  logic [31:0]                   i_now,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output crat_pkg::t_status             o_status,
    output logic [crat_pkg::IDX_W-1:0]    o_rd_addr,
    input  crat_pkg::t_entry              i_rd_data,
    output crat_pkg::t_wr_req             o_wr,
    output logic [31:0]                   o_cmp_x,
    output logic [31:0]                   o_cmp_y,
    input  crat_pkg::t_cmp                i_cmp
);

    crat_pkg::t_state               r_state, n_state;
    crat_pkg::t_mode                r_mode, n_mode;
    logic [31:0]                    r_addr, n_addr;
    logic [31:0]                    r_now, n_now;
    logic [crat_pkg::OCC_W-1:0]     r_idx, n_idx;
    logic [crat_pkg::OCC_W-1:0]     r_wr, n_wr;
    logic [crat_pkg::OCC_W-1:0]     r_occ, n_occ;
    logic [31:0]                    r_next_id, n_next_id;
    crat_pkg::t_status              r_status, n_status;

    logic accept;
    logic scan_end;
    logic is_sweep;

    assign accept   = i_req_valid && o_req_ready;
    assign scan_end = (r_idx == r_occ);
    assign is_sweep = (r_mode == crat_pkg::MODE_SWEEP);

    assign o_req_ready = (r_state == crat_pkg::S_IDLE);
    assign o_res_valid = (r_state == crat_pkg::S_DONE);
    assign o_status    = r_status;
    assign o_rd_addr   = r_idx[crat_pkg::IDX_W-1:0];
    assign o_cmp_x     = is_sweep ? r_now : r_addr;
    assign o_cmp_y     = is_sweep ? i_rd_data.seen : i_rd_data.addr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crat_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == crat_pkg::MODE_NONE) ? crat_pkg::S_DONE
                                                              : crat_pkg::S_SCAN;
                end
            end
            crat_pkg::S_SCAN: begin
                n_state = scan_end ? crat_pkg::S_DONE : crat_pkg::S_CHECK;
            end
            crat_pkg::S_CHECK: begin
                n_state = (!is_sweep && i_cmp.hit) ? crat_pkg::S_DONE : crat_pkg::S_SCAN;
            end
            crat_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = crat_pkg::S_IDLE;
                end
            end
            default: n_state = crat_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_now     = r_now;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_occ     = r_occ;
        n_next_id = r_next_id;
        n_status  = r_status;
        o_wr.en   = 1'b0;
        o_wr.addr = r_idx[crat_pkg::IDX_W-1:0];
        o_wr.data = i_rd_data;
        unique case (r_state)
            crat_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode   = i_mode;
                    n_addr   = i_addr;
                    n_now    = i_now;
                    n_idx    = '0;
                    n_wr     = '0;
                    n_status = crat_pkg::ST_UNKNOWN;
                end
            end
            crat_pkg::S_SCAN: begin
                if (scan_end) begin
                    unique case (r_mode)
                        crat_pkg::MODE_REG: begin
                            if (r_occ == crat_pkg::OCC_W'(crat_pkg::CAPACITY)) begin
                                n_status = crat_pkg::ST_FULL;
                            end else begin
                                o_wr.en   = 1'b1;
                                o_wr.addr = r_occ[crat_pkg::IDX_W-1:0];
                                o_wr.data = '{id: r_next_id, seen: r_now, addr: r_addr};
                                n_occ     = r_occ + 1'b1;
                                n_next_id = r_next_id + 32'd1;
                                n_status  = crat_pkg::ST_NEW;
                            end
                        end
                        crat_pkg::MODE_SWEEP: begin
                            n_occ    = r_wr;
                            n_status = crat_pkg::ST_SWEPT;
                        end
                        default: n_status = crat_pkg::ST_UNKNOWN;
                    endcase
                end
            end
            crat_pkg::S_CHECK: begin
                n_idx = r_idx + 1'b1;
                if (is_sweep) begin
                    if (i_cmp.keep) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = r_wr[crat_pkg::IDX_W-1:0];
                        n_wr      = r_wr + 1'b1;
                    end
                end else if (i_cmp.hit) begin
                    o_wr.en       = 1'b1;
                    o_wr.data.seen = r_now;
                    n_status = (r_mode == crat_pkg::MODE_REG) ? crat_pkg::ST_KNOWN
                                                              : crat_pkg::ST_HB_OK;
                end
            end
            crat_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= crat_pkg::S_IDLE;
            r_occ     <= '0;
            r_next_id <= '0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_addr   <= n_addr;
        r_now    <= n_now;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_status <= n_status;
    end

endmodule

### rtl/client_registry_aging_table.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tuser: mode; tdata: client_addr, now_ms
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: status
// cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_data: timeout_ms
//
// Each table entry scanned takes one read of the
// entry memory and one pass through the shared subtractor.
// Register and heartbeat stop at the first match; sweep visits every entry.
// Synchronous active-low reset empties the table and clears the ID counter.
// A finished status waits in the output register; the next word is taken meanwhile.
module client_registry_aging_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic [63:0] s_axis_tdata,   // [31:0] client_addr, [63:32] now_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] status, [7:3] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]                 r_timeout;
    logic                        r_out_valid;
    crat_pkg::t_status           r_out_status;

    logic                        res_valid;
    logic                        res_ready;
    crat_pkg::t_status           res_status;
    logic [crat_pkg::IDX_W-1:0]  rd_addr;
    crat_pkg::t_entry            rd_data;
    crat_pkg::t_wr_req           wr_req;
    logic [31:0]                 cmp_x;
    logic [31:0]                 cmp_y;
    crat_pkg::t_cmp              cmp_res;

    assign o_cfg_ready   = 1'b1;
    assign res_ready     = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= crat_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_status <= res_status;
        end
    end

    crat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_addr      (s_axis_tdata[31:0]),
        .i_now       (s_axis_tdata[63:32]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_status    (res_status),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr        (wr_req),
        .o_cmp_x     (cmp_x),
        .o_cmp_y     (cmp_y),
        .i_cmp       (cmp_res)
    );

    crat_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    crat_unit u_unit (
        .i_x     (cmp_x),
        .i_y     (cmp_y),
        .i_limit (r_timeout),
        .o_res   (cmp_res)
    );

endmodule

### rtl/crat_checker.sv
module crat_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata
);

    // busy after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after accept");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= crat_pkg::ST_SWEPT
                           && m_axis_tdata[7:3] == 5'd0))
        else $error("illegal status word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind client_registry_aging_table crat_checker u_crat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_client_registry_aging_table.sv
`timescale 1ns / 100ps

module tb_client_registry_aging_table;

    localparam int SETTLE_CYCLES  = 2 * crat_pkg::CAPACITY + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE      = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = crat_pkg::MODE_REG;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    // Shadow of the table
    logic [31:0] tbl_addr [crat_pkg::CAPACITY];
    logic [31:0] tbl_id   [crat_pkg::CAPACITY];
    logic [31:0] tbl_seen [crat_pkg::CAPACITY];
    int          tbl_occ = 0;
    logic [31:0] tbl_next_id = '0;
    logic [31:0] tbl_timeout = crat_pkg::TIMEOUT_RESET;

    crat_pkg::t_status status_expected[$];

    bit no_idle = 1'b0;
    bit hold_outputs = 1'b0;
    int fail_count = 0;
    int words_sent = 0;
    int statuses_checked = 0;
    int timeout_writes = 0;
    int hold_count = 0;
    int idle_cycles = 0;
    int status_tally[8];

    client_registry_aging_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic crat_pkg::t_status registry_apply(input crat_pkg::t_mode mode,
                                                         input logic [31:0] addr,
                                                         input logic [31:0] now);
        int                slot;
        int                wr;
        logic [31:0]       age;
        crat_pkg::t_status st;
        st = crat_pkg::ST_UNKNOWN;
        slot = -1;
        for (int i = 0; i < tbl_occ; i++) begin
            if (slot < 0 && tbl_addr[i] == addr) begin
                slot = i;
            end
        end
        case (mode)
            crat_pkg::MODE_REG: begin
                if (slot >= 0) begin
                    tbl_seen[slot] = now;
                    st = crat_pkg::ST_KNOWN;
                end else if (tbl_occ >= crat_pkg::CAPACITY) begin
                    st = crat_pkg::ST_FULL;
                end else begin
                    tbl_addr[tbl_occ] = addr;
                    tbl_id[tbl_occ]   = tbl_next_id;
                    tbl_seen[tbl_occ] = now;
                    tbl_occ++;
                    tbl_next_id = tbl_next_id + 32'd1;
                    st = crat_pkg::ST_NEW;
                end
            end
            crat_pkg::MODE_HB: begin
                if (slot >= 0) begin
                    tbl_seen[slot] = now;
                    st = crat_pkg::ST_HB_OK;
                end
            end
            crat_pkg::MODE_SWEEP: begin
                wr = 0;
                for (int rd = 0; rd < tbl_occ; rd++) begin
                    age = now - tbl_seen[rd];
                    if (age <= tbl_timeout) begin
                        tbl_addr[wr] = tbl_addr[rd];
                        tbl_id[wr]   = tbl_id[rd];
                        tbl_seen[wr] = tbl_seen[rd];
                        wr++;
                    end
                end
                tbl_occ = wr;
                st = crat_pkg::ST_SWEPT;
            end
            default: st = crat_pkg::ST_UNKNOWN;
        endcase
        return st;
    endfunction

    // Status checker
    always @(posedge i_clk) begin
        crat_pkg::t_status exp_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_expected.size() == 0) begin
                $error("status: no word expected, actual %0d", m_axis_tdata[2:0]);
                fail_count++;
            end else begin
                exp_status = status_expected.pop_front();
                statuses_checked++;
                status_tally[exp_status]++;
                if (m_axis_tdata[2:0] !== exp_status) begin
                    $error("status: expected %0d, actual %0d", exp_status, m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[7:3] !== 5'd0) begin
                    $error("pad: expected 0, actual %0d", m_axis_tdata[7:3]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver pacing, with the occasional long hold-off
    initial begin : result_drain
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_outputs) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_outputs = 1'b0;
                hold_count++;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 13);
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input crat_pkg::t_mode mode, input logic [31:0] addr,
                             input logic [31:0] now);
        int gap;
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {now, addr};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        status_expected.insert(status_expected.size(), registry_apply(mode, addr, now));
        words_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (status_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tbl_timeout = value;
        timeout_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_word(crat_pkg::MODE_HB, 32'h0, 32'h0);
        send_word(crat_pkg::MODE_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(crat_pkg::MODE_REG, 32'h0, 32'h0);
        send_word(crat_pkg::MODE_REG, 32'h0, 32'hFFFF_FFFF);
        send_word(crat_pkg::MODE_HB, 32'h0, 32'd5);
        send_word(crat_pkg::MODE_HB, 32'hFFFF_FFFF, 32'h0);
        send_word(crat_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stop_sending();
        drain_results();
    endtask

    // Seen times straddle the 32-bit wrap
    task automatic test_full_table();
        for (int i = 1; i < crat_pkg::CAPACITY; i++) begin
            send_word(crat_pkg::MODE_REG,
                      (i == crat_pkg::CAPACITY - 1) ? 32'hFFFF_FFFF : $urandom,
                      32'hFFFF_FF80 + 32'(i * 10));
        end
        send_word(crat_pkg::MODE_REG, $urandom, 32'hFFFF_FFE0);
        send_word(crat_pkg::MODE_REG, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        stop_sending();
        drain_results();
    endtask

    task automatic test_sweep_edges();
        send_word(crat_pkg::MODE_SWEEP, $urandom, 32'h0);
        stop_sending();
        write_timeout(32'd0);
        send_word(crat_pkg::MODE_REG, 32'hFFFF_FFFF, 32'h10);
        send_word(crat_pkg::MODE_SWEEP, $urandom, 32'h10);
        stop_sending();
        write_timeout(32'hFFFF_FFFF);
        send_word(crat_pkg::MODE_SWEEP, $urandom, $urandom);
        stop_sending();
        drain_results();
    endtask

    task automatic test_random_traffic(input logic [31:0] timeout, input int n_words,
                                       input bit quiet);
        logic [31:0]     pool [POOL_SIZE];
        logic [31:0]     now;
        logic [31:0]     step_max;
        logic [31:0]     addr;
        crat_pkg::t_mode mode;
        int              r;
        write_timeout(timeout);
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        now = $urandom;
        step_max = (timeout > 32'd4) ? (timeout >> 2) : 32'd1;
        no_idle = quiet;
        for (int n = 0; n < n_words; n++) begin
            r = $urandom_range(0, 99);
            addr = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 31) == 0) begin
                now = now - $urandom_range(0, step_max);
            end else begin
                now = now + $urandom_range(0, step_max);
            end
            if (r < 45) begin
                mode = crat_pkg::MODE_REG;
            end else if (r < 80) begin
                mode = crat_pkg::MODE_HB;
            end else if (r < 94) begin
                mode = crat_pkg::MODE_SWEEP;
            end else begin
                mode = crat_pkg::MODE_NONE;
            end
            send_word(mode, addr, now);
        end
        stop_sending();
        no_idle = 1'b0;
    endtask

    // Output held off while words keep coming, so the input stalls
    task automatic test_backpressure();
        logic [31:0] now;
        now = $urandom;
        hold_outputs = 1'b1;
        no_idle = 1'b1;
        for (int n = 0; n < 40; n++) begin
            now = now + $urandom_range(0, 2000);
            send_word(($urandom_range(0, 1) == 0) ? crat_pkg::MODE_REG : crat_pkg::MODE_HB,
                      $urandom_range(0, 23), now);
        end
        stop_sending();
        no_idle = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_full_table();
        test_sweep_edges();
        test_random_traffic(crat_pkg::TIMEOUT_RESET, 230, 1'b0);
        test_random_traffic(32'd1, 230, 1'b0);
        test_random_traffic(32'hFFFF_FFFF, 200, 1'b0);
        test_random_traffic($urandom_range(2, 1000), 230, 1'b1);
        test_random_traffic($urandom_range(1, 32'hFFFF_FFFF), 200, 1'b0);
        test_random_traffic(32'd5000, 250, 1'b0);
        test_random_traffic($urandom_range(10, 100000), 250, 1'b0);
        test_random_traffic(32'd100, 230, 1'b0);
        test_backpressure();
        $display("Run: %0d words sent, %0d statuses checked, %0d timeout writes, %0d hold-offs",
                 words_sent, statuses_checked, timeout_writes, hold_count);
        $display("Statuses: new %0d known %0d hb %0d unknown %0d full %0d swept %0d",
                 status_tally[crat_pkg::ST_NEW], status_tally[crat_pkg::ST_KNOWN],
                 status_tally[crat_pkg::ST_HB_OK], status_tally[crat_pkg::ST_UNKNOWN],
                 status_tally[crat_pkg::ST_FULL], status_tally[crat_pkg::ST_SWEPT]);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/crat_pkg.sv
rtl/crat_table.sv
rtl/crat_unit.sv
rtl/crat_ctrl.sv
rtl/client_registry_aging_table.sv
rtl/crat_checker.sv
tb/sv/tb_client_registry_aging_table.sv
